FILE: sv/chte_pkg.sv
// ----------------------------------------------------------------------------
// chte_pkg: shared types and constants of the chained hash table engine
// Holds the controller state type, the response codes and the
// command and status groups passed between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package chte_pkg;

	// integer mix hash multiplier
	localparam logic [31:0] HASH_MUL = 32'h045d_9f3b;
	// bucket count after reset
	localparam logic [10:0] BUCKETS_RESET = 11'd1021;
	// request kinds
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	typedef enum logic [2:0] {
		RSP_NEW   = 3'd0,
		RSP_UPD   = 3'd1,
		RSP_FULL  = 3'd2,
		RSP_FOUND = 3'd3,
		RSP_MISS  = 3'd4
	} rsp_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_MIX1,
		S_MIX2,
		S_DINIT,
		S_DIV,
		S_HREAD,
		S_HCHK,
		S_EREAD,
		S_ECHK,
		S_FIN,
		S_LINK,
		S_OUT
	} state_t;

	typedef struct packed {
		logic clr;
		logic load_in;
		logic mix1;
		logic mix2;
		logic div_init;
		logic div_step;
		logic head_chk;
		logic ent_chk;
		logic fin;
		logic link;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic div_last;
		logic head_vld;
		logic key_hit;
		logic nxt_vld;
		logic alloc;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

FILE: sv/chained_hash_table_engine_unit.sv
// Each request passes a 32-step modulo and walks the chain entries one by one;
// an insert that takes a new entry passes an extra link state before the result.
// Throughput: one request at a time; the next is taken once the result
// sits in the output register.
// Reset: a clearing pass over all MAX_BUCKETS bucket heads empties them,
// in_ready stays low meanwhile; bucket_count writes are taken throughout.
// ----------------------------------------------------------------------------
// chained_hash_table_engine_unit: chained hash table key-value store
// Insert/update and lookup of signed 32-bit keys over a fixed entry pool.
// ----------------------------------------------------------------------------
`default_nettype none
module chained_hash_table_engine_unit import chte_pkg::*; #(
	parameter int MAX_BUCKETS  = 1024,
	parameter int POOL_ENTRIES = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               bucket_count_we,
	input  wire logic        [10:0] bucket_count,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               action,
	input  wire logic signed [31:0] key,
	input  wire logic signed [31:0] value,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic              [2:0] status,
	output logic signed      [31:0] read_value,
	output logic             [31:0] collision_count
);

	cmd_t cmd;
	sts_t sts;

	// sequencer
	chte_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.sts(sts), .cmd(cmd)
	);

	// datapath
	chte_dpath #(.MAX_BUCKETS(MAX_BUCKETS), .POOL_ENTRIES(POOL_ENTRIES)) u_dpath (
		.clk(clk), .arst_n(arst_n),
		.bucket_count_we(bucket_count_we), .bucket_count(bucket_count),
		.action(action), .key(key), .value(value),
		.cmd(cmd), .sts(sts),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.read_value(read_value), .collision_count(collision_count)
	);

endmodule
`default_nettype wire

FILE: sv/chte_ram.sv
// ----------------------------------------------------------------------------
// chte_ram: generic single write, single read memory
// One write port and one read port with the read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module chte_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: sv/chte_ctrl.sv
// ----------------------------------------------------------------------------
// chte_ctrl: request sequencer
// Steps each request through hashing, bucket selection, chain walk,
// table update and response hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
module chte_ctrl import chte_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (sts.clr_last) state_d = S_IDLE;
			S_IDLE:  if (in_valid) state_d = S_MIX1;
			S_MIX1:  state_d = S_MIX2;
			S_MIX2:  state_d = S_DINIT;
			S_DINIT: state_d = S_DIV;
			S_DIV:   if (sts.div_last) state_d = S_HREAD;
			S_HREAD: state_d = S_HCHK;
			S_HCHK:  state_d = sts.head_vld ? S_EREAD : S_FIN;
			S_EREAD: state_d = S_ECHK;
			S_ECHK: begin
				priority if (sts.key_hit) state_d = S_FIN;
				else if (sts.nxt_vld) state_d = S_EREAD;
				else state_d = S_FIN;
			end
			S_FIN:   state_d = sts.alloc ? S_LINK : S_OUT;
			S_LINK:  state_d = S_OUT;
			S_OUT:   if (sts.out_free) state_d = S_IDLE;
			default: state_d = S_CLEAR;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: cmd.clr = 1'b1;
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			S_MIX1:  cmd.mix1 = 1'b1;
			S_MIX2:  cmd.mix2 = 1'b1;
			S_DINIT: cmd.div_init = 1'b1;
			S_DIV:   cmd.div_step = 1'b1;
			S_HCHK:  cmd.head_chk = 1'b1;
			S_ECHK:  cmd.ent_chk = 1'b1;
			S_FIN:   cmd.fin = 1'b1;
			S_LINK:  cmd.link = 1'b1;
			S_OUT:   cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

FILE: sv/chte_dpath.sv
// ----------------------------------------------------------------------------
// chte_dpath: hash table datapath
// Mix hash, bit-serial modulo, bucket heads and entry pool memories,
// chain walk registers, counters and the response register.
// ----------------------------------------------------------------------------
`default_nettype none
module chte_dpath import chte_pkg::*; #(
	parameter int MAX_BUCKETS  = 1024,
	parameter int POOL_ENTRIES = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               bucket_count_we,
	input  wire logic        [10:0] bucket_count,
	input  wire logic               action,
	input  wire logic signed [31:0] key,
	input  wire logic signed [31:0] value,
	input  wire cmd_t               cmd,
	output sts_t                    sts,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic              [2:0] status,
	output logic signed      [31:0] read_value,
	output logic             [31:0] collision_count
);

	localparam int BW = $clog2(MAX_BUCKETS);
	localparam int PW = $clog2(POOL_ENTRIES);
	localparam int NW = $clog2(MAX_BUCKETS + 1);
	localparam int RW = NW + 1;
	localparam int UW = $clog2(POOL_ENTRIES + 1);

	logic [10:0]   cfg_q;
	logic          act_q;
	logic [31:0]   key_q, val_q, x_q, d_q, rd_q, coll_q;
	logic [RW-1:0] rem_q;
	logic [4:0]    cnt_q;
	logic [BW-1:0] clr_q;
	logic [PW-1:0] cur_q;
	logic [UW-1:0] used_q;
	logic          found_q, hvld_q;
	rsp_t          rsp_q;
	logic          ovld_q;
	logic [2:0]    ostat_q;
	logic [31:0]   ord_q, ocoll_q;

	logic [NW-1:0] n;
	logic [31:0]   mix_in, mix_x, mix_p;
	logic [RW-1:0] trial;
	logic [BW-1:0] bucket;
	logic [PW-1:0] used_idx;
	logic          full;

	// bucket count limited to one up to the table size
	always_comb begin
		priority if (cfg_q == '0) n = NW'(1);
		else if (32'(cfg_q) > 32'(MAX_BUCKETS)) n = NW'(MAX_BUCKETS);
		else n = NW'(cfg_q);
	end

	// one mix round, xor-shift then multiply
	assign mix_in = cmd.mix1 ? key_q : x_q;
	assign mix_x  = mix_in ^ (mix_in >> 16);
	assign mix_p  = 32'(mix_x * HASH_MUL);

	// one restoring step of the modulo
	assign trial    = {rem_q[RW-2:0], d_q[31]};
	assign bucket   = rem_q[BW-1:0];
	assign used_idx = used_q[PW-1:0];
	assign full     = 32'(used_q) >= 32'(POOL_ENTRIES);

	// memories
	logic          h_we;
	logic [BW-1:0] h_wa;
	logic [PW:0]   h_wd, h_rd;
	logic          k_we, v_we, n_we;
	logic [PW-1:0] v_wa, n_wa;
	logic [PW:0]   n_wd, n_rd;
	logic [31:0]   k_rd, v_rd;

	assign h_we = cmd.clr || (cmd.link && !hvld_q);
	assign h_wa = cmd.clr ? clr_q : bucket;
	assign h_wd = cmd.clr ? '0 : {1'b1, used_idx};

	assign k_we = cmd.fin && sts.alloc;
	assign v_we = cmd.fin && (sts.alloc || (found_q && act_q == ACT_INSERT));
	assign v_wa = found_q ? cur_q : used_idx;
	assign n_we = (cmd.fin && sts.alloc) || (cmd.link && hvld_q);
	assign n_wa = cmd.link ? cur_q : used_idx;
	assign n_wd = cmd.link ? {1'b1, used_idx} : '0;

	chte_ram #(.WIDTH(PW + 1), .DEPTH(MAX_BUCKETS)) u_head (
		.clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(bucket), .rdata_q(h_rd)
	);
	chte_ram #(.WIDTH(32), .DEPTH(POOL_ENTRIES)) u_key (
		.clk(clk), .we(k_we), .waddr(used_idx), .wdata(key_q), .raddr(cur_q), .rdata_q(k_rd)
	);
	chte_ram #(.WIDTH(32), .DEPTH(POOL_ENTRIES)) u_val (
		.clk(clk), .we(v_we), .waddr(v_wa), .wdata(val_q), .raddr(cur_q), .rdata_q(v_rd)
	);
	chte_ram #(.WIDTH(PW + 1), .DEPTH(POOL_ENTRIES)) u_next (
		.clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(cur_q), .rdata_q(n_rd)
	);

	// status towards the controller
	always_comb begin
		sts.clr_last = clr_q == BW'(MAX_BUCKETS - 1);
		sts.div_last = cnt_q == 5'd31;
		sts.head_vld = h_rd[PW];
		sts.key_hit  = k_rd == key_q;
		sts.nxt_vld  = n_rd[PW];
		sts.alloc    = act_q == ACT_INSERT && !found_q && !full;
		sts.out_free = !ovld_q || out_ready;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q   <= BUCKETS_RESET;
			clr_q   <= '0;
			used_q  <= '0;
			coll_q  <= '0;
			ovld_q  <= 1'b0;
			found_q <= 1'b0;
			hvld_q  <= 1'b0;
		end else begin
			if (bucket_count_we) cfg_q <= bucket_count;
			if (cmd.clr) clr_q <= clr_q + 1'b1;
			if (cmd.load_in) found_q <= 1'b0;
			if (cmd.head_chk) hvld_q <= h_rd[PW];
			if (cmd.ent_chk && sts.key_hit) found_q <= 1'b1;
			if (cmd.link) used_q <= used_q + 1'b1;
			if (cmd.fin && act_q == ACT_INSERT && hvld_q && coll_q != '1) begin
				coll_q <= coll_q + 1'b1;
			end
			if (cmd.out_load) ovld_q <= 1'b1;
			else if (out_ready) ovld_q <= 1'b0;
		end
	end

	// request, hash, walk and response payload
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			act_q <= action;
			key_q <= key;
			val_q <= value;
			rd_q  <= '1;
		end
		if (cmd.mix1 || cmd.mix2) x_q <= mix_p;
		if (cmd.div_init) begin
			d_q   <= x_q ^ (x_q >> 16);
			rem_q <= '0;
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			d_q   <= {d_q[30:0], 1'b0};
			cnt_q <= cnt_q + 1'b1;
			rem_q <= (trial >= RW'(n)) ? trial - RW'(n) : trial;
		end
		if (cmd.head_chk) cur_q <= h_rd[PW-1:0];
		// the tail entry stays in cur_q for linking
		if (cmd.ent_chk && !sts.key_hit && sts.nxt_vld) cur_q <= n_rd[PW-1:0];
		if (cmd.ent_chk && sts.key_hit && act_q == ACT_LOOKUP) rd_q <= v_rd;
		if (cmd.fin) begin
			priority if (act_q == ACT_LOOKUP) rsp_q <= found_q ? RSP_FOUND : RSP_MISS;
			else if (found_q) rsp_q <= RSP_UPD;
			else if (full) rsp_q <= RSP_FULL;
			else rsp_q <= RSP_NEW;
		end
		if (cmd.out_load) begin
			ostat_q <= rsp_q;
			ord_q   <= rd_q;
			ocoll_q <= coll_q;
		end
	end

	assign out_valid       = ovld_q;
	assign status          = ostat_q;
	assign read_value      = ord_q;
	assign collision_count = ocoll_q;

endmodule
`default_nettype wire

FILE: sv/chte_checker.sv
// ----------------------------------------------------------------------------
// chte_checker: port level checks of the hash table engine
// Watches the response word and the collision counter over time.
// ----------------------------------------------------------------------------
`default_nettype none
module chte_checker import chte_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  status,
	input wire logic [31:0] read_value,
	input wire logic [31:0] collision_count
);

	// a stalled word stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("response dropped while stalled");

	// only a hit carries a value
	a_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != RSP_FOUND |-> read_value == 32'hffff_ffff)
		else $error("value on a response without a hit");

	// status stays within the response codes
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= RSP_MISS)
		else $error("unknown response code");

	// collision counter never goes back between delivered words
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && $past(out_valid) && $past(arst_n)
			|-> collision_count >= $past(collision_count))
		else $error("collision counter went backwards");

endmodule

bind chained_hash_table_engine_unit chte_checker u_chte_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.status(status), .read_value(read_value), .collision_count(collision_count)
);
`default_nettype wire
